### design/a1ref_pkg.sv
// ----------------------------------------------------------------------------
// a1ref_pkg
// Shared types and constants for the A1 cell reference parser.
// ----------------------------------------------------------------------------
`default_nettype none

package a1ref_pkg;

    localparam int ACC_W = 31;

    // character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_COL   = 3'd1,
        PH_ROW   = 3'd2,
        PH_TRAIL = 3'd3,
        PH_BAD   = 3'd4,
        PH_OVF   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BLANK    = 2'd1,
        ST_INVALID  = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        logic ws;
        logic letter;
        logic digit;
    } t_char_class;

    typedef struct packed {
        t_status            status;
        logic [ACC_W-1:0]   row_index;
        logic [ACC_W-1:0]   column_index;
    } t_result;

endpackage

`default_nettype wire

### design/a1ref_char_class.sv
// ----------------------------------------------------------------------------
// a1ref_char_class
// Classifies one byte as whitespace, letter or digit.
// ----------------------------------------------------------------------------
`default_nettype none

module a1ref_char_class
    import a1ref_pkg::*;
(
    input  wire logic [7:0]  i_ch,
    output t_char_class      o_class
);

    always_comb begin
        o_class.ws     = (i_ch == CH_SPACE) || (i_ch == CH_TAB) || (i_ch == CH_LF) ||
                         (i_ch == CH_CR) || (i_ch == CH_FF) || (i_ch == CH_VT);
        o_class.letter = ((i_ch >= CH_UPPER_A) && (i_ch <= CH_UPPER_Z)) ||
                         ((i_ch >= CH_LOWER_A) && (i_ch <= CH_LOWER_Z));
        o_class.digit  = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    end

endmodule

`default_nettype wire

### design/a1ref_parse_core.sv
// ----------------------------------------------------------------------------
// a1ref_parse_core
// Phase register and column/row accumulators; one character per cycle with
// i_go high; result formed combinationally from the updated state on the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module a1ref_parse_core
    import a1ref_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_last,
    output t_result          o_result
);

    t_char_class       w_class;
    t_phase            r_phase, n_phase;
    logic [ACC_W-1:0]  r_col, n_col;
    logic [ACC_W-1:0]  r_row, n_row;
    logic [7:0]        w_letter_diff;
    logic [4:0]        w_letter_val;
    logic [3:0]        w_digit_val;
    logic [ACC_W+5:0]  w_col_ext, w_col_mul;
    logic [ACC_W+3:0]  w_row_ext, w_row_mul;
    logic              w_col_ovf, w_row_ovf;
    logic              w_take_letter, w_take_digit;

    a1ref_char_class u_class (
        .i_ch    (i_ch),
        .o_class (w_class)
    );

    // x*26 = x*16 + x*8 + x*2, x*10 = x*8 + x*2
    always_comb begin
        w_letter_diff = i_ch - ((i_ch >= CH_LOWER_A) ? (CH_LOWER_A - 8'd1)
                                                     : (CH_UPPER_A - 8'd1));
        w_letter_val  = w_letter_diff[4:0];
        w_digit_val   = i_ch[3:0];
        w_col_ext     = {6'd0, r_col};
        w_col_mul     = (w_col_ext << 4) + (w_col_ext << 3) + (w_col_ext << 1)
                        + {{(ACC_W+1){1'b0}}, w_letter_val};
        w_col_ovf     = |w_col_mul[ACC_W+5:ACC_W];
        w_row_ext     = {4'd0, r_row};
        w_row_mul     = (w_row_ext << 3) + (w_row_ext << 1)
                        + {{ACC_W{1'b0}}, w_digit_val};
        w_row_ovf     = |w_row_mul[ACC_W+3:ACC_W];
    end

    always_comb begin
        n_phase       = r_phase;
        n_col         = r_col;
        n_row         = r_row;
        w_take_letter = 1'b0;
        w_take_digit  = 1'b0;
        case (r_phase)
            PH_LEAD: begin
                if (w_class.letter) begin
                    n_phase       = PH_COL;
                    w_take_letter = 1'b1;
                end else if (!w_class.ws) begin
                    n_phase = PH_BAD;
                end
            end
            PH_COL: begin
                if (w_class.letter) begin
                    w_take_letter = 1'b1;
                end else if (w_class.digit) begin
                    n_phase      = PH_ROW;
                    w_take_digit = 1'b1;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_ROW: begin
                if (w_class.digit) begin
                    w_take_digit = 1'b1;
                end else if (w_class.ws) begin
                    n_phase = PH_TRAIL;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_TRAIL: begin
                if (!w_class.ws) begin
                    n_phase = PH_BAD;
                end
            end
            PH_OVF: begin
                n_phase = PH_OVF;
            end
            default: begin
                n_phase = PH_BAD;
            end
        endcase

        if (w_take_letter) begin
            if (w_col_ovf) begin
                n_phase = PH_OVF;
            end else begin
                n_col = w_col_mul[ACC_W-1:0];
            end
        end
        if (w_take_digit) begin
            if (w_row_ovf) begin
                n_phase = PH_OVF;
            end else begin
                n_row = w_row_mul[ACC_W-1:0];
            end
        end
    end

    // result as seen after this character
    always_comb begin
        o_result.status       = ST_INVALID;
        o_result.row_index    = '0;
        o_result.column_index = '0;
        case (n_phase)
            PH_LEAD: begin
                o_result.status = ST_BLANK;
            end
            PH_ROW, PH_TRAIL: begin
                if ((n_row != '0) && (n_col != '0)) begin
                    o_result.status       = ST_OK;
                    o_result.row_index    = n_row - {{(ACC_W-1){1'b0}}, 1'b1};
                    o_result.column_index = n_col - {{(ACC_W-1){1'b0}}, 1'b1};
                end
            end
            PH_OVF: begin
                o_result.status = ST_OVERFLOW;
            end
            default: begin
                o_result.status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_col   <= '0;
            r_row   <= '0;
        end else if (i_go) begin
            // a finished reference starts the next one from scratch
            if (i_last) begin
                r_phase <= PH_LEAD;
                r_col   <= '0;
                r_row   <= '0;
            end else begin
                r_phase <= n_phase;
                r_col   <= n_col;
                r_row   <= n_row;
            end
        end
    end

endmodule

`default_nettype wire

### design/a1_cell_reference_parser_unit.sv
// ----------------------------------------------------------------------------
// a1_cell_reference_parser_unit
// Streams an A1 cell reference one character per request and reports the
// zero-based row and column, or a blank, invalid or overflow status.
// ----------------------------------------------------------------------------
// Slave channel: one character per request in tdata, tlast on the final one.
// Master channel: one result per reference, sent after its tlast character.
// Non-final characters only update the internal accumulators.
// Datapath: input register -> classify and accumulate -> result register.
// Result path: a final character waits in the input register, then its result is registered.
// Throughput: one character per cycle unless a final character stalls as below;
// the single accumulate step updates the column (x26) or row (x10).
// A stalled receiver holds the result register; characters keep flowing
// until a further final character finds the result register still full,
// then tready drops until the result is taken.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the leading-whitespace phase with zero accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module a1_cell_reference_parser_unit
    import a1ref_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,   // [7:0] ch
    input  wire logic         i_s_tlast,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [63:0]       o_m_tdata,   // [30:0] row_index, [61:31] column_index
    output logic [1:0]        o_m_tuser    // [1:0] status
);

    logic        r_in_valid;
    logic [7:0]  r_in_ch;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    t_result     w_result;
    logic        w_go;
    logic        w_in_fire;
    logic        w_out_fire;

    assign w_out_fire = r_out_valid && i_m_tready;
    // a final character needs room in the result register
    assign w_go       = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_go;
    assign w_in_fire  = i_s_tvalid && o_s_tready;

    a1ref_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_ch     (r_in_ch),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_ch   <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {2'b00, r_out.column_index, r_out.row_index};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_err_zero_idx : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_OK)) |->
            ((r_out.row_index == '0) && (r_out.column_index == '0)))
        else $error("non-ok result carries non-zero indices");

    a_stall_holds_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_in_last && r_out_valid))
        else $error("input stalled without a pending final character");

    a_final_loads_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && r_in_last) |=> r_out_valid)
        else $error("final character did not produce a result");

endmodule

`default_nettype wire

### tb/tb_a1_cell_reference_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_a1_cell_reference_parser_unit
// Feeds A1 cell references to the parser one character per request and
// checks every result against a cycle-free model of the parse, under
// random idling on the character side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_a1_cell_reference_parser_unit;

    import a1ref_pkg::*;

    localparam longint unsigned ACC_LIMIT   = 64'd2147483647;
    localparam int              CYCLE_LIMIT = 200000;
    localparam int              TAIL_CYCLES = 20;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } t_char_req;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] ch
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // [30:0] row_index, [61:31] column_index
    logic [1:0]  m_tuser;         // [1:0] status

    t_char_req        char_queue[$];
    t_result          parsed_refs[$];
    logic [7:0]       draft[$];

    t_phase           parse_phase = PH_LEAD;
    logic [ACC_W-1:0] col_acc = '0;
    logic [ACC_W-1:0] row_acc = '0;

    int  idle_pct       = 0;
    int  stall_pct      = 0;
    bit  hold_sender    = 1'b0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;

    a1_cell_reference_parser_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parse model
    // ------------------------------------------------------------------
    function automatic bit is_space(input logic [7:0] ch);
        return ch == CH_SPACE || ch == CH_TAB || ch == CH_LF ||
               ch == CH_CR || ch == CH_FF || ch == CH_VT;
    endfunction

    function automatic bit is_letter(input logic [7:0] ch);
        return (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
               (ch >= CH_LOWER_A && ch <= CH_LOWER_Z);
    endfunction

    function automatic bit is_digit(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    task automatic add_letter(input logic [7:0] ch);
        longint unsigned grown;
        logic [7:0]      base;
        base  = (ch >= CH_LOWER_A) ? CH_LOWER_A : CH_UPPER_A;
        grown = 64'(col_acc) * 64'd26 + 64'(ch - base) + 64'd1;
        if (grown > ACC_LIMIT)
            parse_phase = PH_OVF;
        else
            col_acc = ACC_W'(grown);
    endtask

    task automatic add_digit(input logic [7:0] ch);
        longint unsigned grown;
        grown = 64'(row_acc) * 64'd10 + 64'(ch - CH_ZERO);
        if (grown > ACC_LIMIT)
            parse_phase = PH_OVF;
        else
            row_acc = ACC_W'(grown);
    endtask

    task automatic parse_char(input logic [7:0] ch, input logic fin);
        t_result res;
        case (parse_phase)
            PH_LEAD: begin
                if (!is_space(ch)) begin
                    if (is_letter(ch)) begin
                        parse_phase = PH_COL;
                        add_letter(ch);
                    end else begin
                        parse_phase = PH_BAD;
                    end
                end
            end
            PH_COL: begin
                if (is_letter(ch)) begin
                    add_letter(ch);
                end else if (is_digit(ch)) begin
                    parse_phase = PH_ROW;
                    add_digit(ch);
                end else begin
                    parse_phase = PH_BAD;
                end
            end
            PH_ROW: begin
                if (is_digit(ch))
                    add_digit(ch);
                else if (is_space(ch))
                    parse_phase = PH_TRAIL;
                else
                    parse_phase = PH_BAD;
            end
            PH_TRAIL: begin
                if (!is_space(ch))
                    parse_phase = PH_BAD;
            end
            PH_OVF: ;
            default: parse_phase = PH_BAD;
        endcase

        if (fin) begin
            res = '{status: ST_INVALID, row_index: '0, column_index: '0};
            case (parse_phase)
                PH_LEAD: res.status = ST_BLANK;
                PH_ROW, PH_TRAIL: begin
                    if (row_acc != 0 && col_acc != 0) begin
                        res.status       = ST_OK;
                        res.row_index    = row_acc - 1'b1;
                        res.column_index = col_acc - 1'b1;
                    end
                end
                PH_OVF: res.status = ST_OVERFLOW;
                default: ;
            endcase
            parsed_refs.insert(parsed_refs.size(), res);
            parse_phase = PH_LEAD;
            col_acc     = '0;
            row_acc     = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_CR;
            4: return CH_FF;
            default: return CH_VT;
        endcase
    endfunction

    task automatic queue_draft();
        t_char_req req;
        foreach (draft[i]) begin
            req.ch  = draft[i];
            req.fin = (i == draft.size() - 1);
            char_queue.insert(char_queue.size(), req);
        end
    endtask

    task automatic draft_wellformed();
        longint unsigned col_val;
        longint unsigned row_val;
        logic [7:0]      letters[$];
        logic [7:0]      letter;
        string           digits;
        draft.delete();
        repeat ($urandom_range(0, 2)) draft.insert(draft.size(), pick_space());

        // a few columns and rows sit right on the accumulator limit
        case ($urandom_range(0, 9))
            0:       col_val = 64'd2147483644 + $urandom_range(0, 6);
            1:       col_val = $urandom_range(1, 26);
            default: col_val = $urandom_range(1, 20000);
        endcase
        while (col_val != 0) begin
            col_val = col_val - 1;
            letter  = CH_UPPER_A + 8'(col_val % 26);
            if ($urandom_range(0, 1))
                letter = letter - CH_UPPER_A + CH_LOWER_A;
            letters.push_front(letter);
            col_val = col_val / 26;
        end
        foreach (letters[i]) draft.insert(draft.size(), letters[i]);

        case ($urandom_range(0, 9))
            0:       row_val = 64'd2147483644 + $urandom_range(0, 6);
            1:       row_val = 0;
            default: row_val = $urandom_range(1, 99999);
        endcase
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) draft.insert(draft.size(), CH_ZERO);
        digits = $sformatf("%0d", row_val);
        for (int i = 0; i < digits.len(); i++) draft.insert(draft.size(), digits[i]);

        repeat ($urandom_range(0, 2)) draft.insert(draft.size(), pick_space());
    endtask

    task automatic fill_random(input int count);
        int added;
        added = 0;
        while (added < count) begin
            case ($urandom_range(0, 9))
                7: begin
                    draft_wellformed();
                    draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
                end
                8: begin
                    draft.delete();
                    repeat ($urandom_range(1, 6))
                        draft.insert(draft.size(), 8'($urandom_range(0, 255)));
                end
                9: begin
                    draft_wellformed();
                    draft.insert($urandom_range(0, draft.size()), pick_space());
                end
                default: draft_wellformed();
            endcase
            added += draft.size();
            queue_draft();
        end
    endtask

    task automatic wait_sent();
        while (char_queue.size() != 0 || s_tvalid) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (parsed_refs.size() != 0) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // character driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
            if (!s_tvalid || s_tready) begin
                if (s_tvalid)
                    char_queue.delete(0);
                if (char_queue.size() != 0 && !hold_sender &&
                        $urandom_range(0, 99) >= idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= char_queue[0].ch;
                    s_tlast  <= char_queue[0].fin;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: check results first, then model the accepted character
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (parsed_refs.size() == 0) begin
                    report_mismatch("result with nothing pending, status", m_tuser, 0);
                end else begin
                    want = parsed_refs.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[30:0] !== want.row_index)
                        report_mismatch("row_index", m_tdata[30:0], want.row_index);
                    if (m_tdata[61:31] !== want.column_index)
                        report_mismatch("column_index", m_tdata[61:31], want.column_index);
                end
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata, s_tlast);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // leading/trailing space, lowercase, ok at origin
        draft = '{CH_SPACE, CH_LOWER_A, "1", CH_TAB};   queue_draft();
        // row zero
        draft = '{CH_UPPER_Z, CH_ZERO};                 queue_draft();
        // digit with no letters
        draft = '{"7"};                                 queue_draft();
        // letters with no digits
        draft = '{"b"};                                 queue_draft();
        // all whitespace
        draft = '{CH_LF, CH_VT, CH_FF, CH_CR};          queue_draft();
        // space between letters and digits
        draft = '{CH_UPPER_A, CH_SPACE, "1"};           queue_draft();
        // byte extremes
        draft = '{8'hFF};                               queue_draft();
        draft = '{8'h00};                               queue_draft();
        // column overflow, later digit ignored
        draft = '{CH_LOWER_Z, CH_UPPER_Z, CH_LOWER_Z, CH_UPPER_Z,
                  CH_LOWER_Z, CH_UPPER_Z, CH_LOWER_Z, CH_NINE};
        queue_draft();
        wait_sent();

        // sender holds back until every result is out
        hold_sender = 1'b1;
        fill_random(190);
        wait_drained();
        hold_sender = 1'b0;
        wait_sent();

        idle_pct  = 49;
        stall_pct = 0;
        fill_random(190);
        wait_sent();

        idle_pct  = 0;
        stall_pct = 49;
        fill_random(190);
        wait_sent();

        idle_pct  = 35;
        stall_pct = 35;
        fill_random(190);
        wait_sent();

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
